@@ rtl/core/tit_pkg.sv @@
// ============================================================================
// tit_pkg - trickle interval timer shared definitions
// Payload structs, function codes, register indexes and reset values.
// ============================================================================
package tit_pkg;

  // Field widths
  localparam int FUNC_W     = 2;
  localparam int RANDOM_W   = 16;
  localparam int EXP_W      = 5;
  localparam int DOUB_W     = 5;
  localparam int RED_W      = 8;
  localparam int TPS_W      = 11;
  localparam int CNT_W      = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;

  // Default parameter values
  localparam int RAND_MAX_DEFAULT = 65535;
  localparam int EXP_MAX_DEFAULT  = 24;

  // Milliseconds per second for the tick conversion
  localparam int MS_PER_SEC = 1000;
  localparam int MS_W       = $clog2(MS_PER_SEC + 1);

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_HEARD = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_EXP    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DOUBLINGS  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REDUNDANCY = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TPS        = 2'd3;

  // Register reset values
  localparam logic [EXP_W-1:0]  MIN_EXP_RST   = 5'd12;
  localparam logic [DOUB_W-1:0] DOUBLINGS_RST = 5'd8;
  localparam logic [RED_W-1:0]  RED_RST       = 8'd10;
  localparam logic [TPS_W-1:0]  TPS_RST       = 11'd128;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [RANDOM_W-1:0] random_value;
    logic                link_ready;
  } tit_in_t;

  typedef struct packed {
    logic             send_now;
    logic             suppressed;
    logic             postponed;
    logic             new_interval;
    logic [EXP_W-1:0] interval_exp;
  } tit_out_t;

endpackage

@@ rtl/core/tit_serial_mul.sv @@
// ============================================================================
// tit_serial_mul - bit-serial shift-add multiplier
// One bit of the multiplier per cycle, LSB first.
// ============================================================================
module tit_serial_mul #(
  parameter int A_W = 31,
  parameter int B_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [A_W-1:0]   a_i,
  input  logic [B_W-1:0]   b_i,
  output logic             done_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int CW = $clog2(B_W + 1);

  logic [A_W-1:0] a_q;
  logic [A_W-1:0] hi_q;
  logic [B_W-1:0] lo_q;
  logic [CW-1:0]  cnt_q;
  logic           done_q;
  logic [A_W:0]   sum;

  // add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, hi_q} + {1'b0, (lo_q[0] ? a_q : '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(B_W);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (cnt_q != '0) begin
      hi_q <= sum[A_W:1];
      lo_q <= {sum[0], lo_q[B_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

@@ rtl/core/tit_serial_div.sv @@
// ============================================================================
// tit_serial_div - bit-serial restoring divider
// One quotient bit per cycle, MSB first.
// ============================================================================
module tit_serial_div #(
  parameter int W  = 47,
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [W-1:0]  quot_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc_q;   // dividend bits out at the top, quotient bits in below
  logic [DW-1:0] rem_q;
  logic [DW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_q, acc_q[W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(W);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      acc_q <= {acc_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

@@ rtl/core/trickle_interval_timer.sv @@
// ============================================================================
// trickle_interval_timer - Trickle timer with serial interval arithmetic
// Keeps interval exponent, firing countdown and heard counter; one result
// transfer per input transfer.
// ============================================================================
//
//  port group  | dir | handshake                | payload
//  ------------+-----+--------------------------+-----------------------------
//  in          | in  | in_valid_i / in_ready_o  | in_data_i  (tit_in_t)
//  out         | out | out_valid_o / out_ready_i| out_data_o (tit_out_t)
//  cfg         | in  | cfg_we_i (no wait)       | cfg_addr_i, cfg_wdata_i
//
//  Sequence: an item that does not open a new interval goes straight to the
//    done state after its input transfer. An item that opens one runs the
//    length division, the shift-add multiply and the fraction division in
//    that order; both divisions run on the single shared serial divider.
//    The next input is taken once the result has moved to the output register.
//  Reset: all control and timer state cleared, registers at their defaults.
//  Stalls: a finished result sits in the output register; the next item is
//    taken meanwhile and waits at its end until the register frees up.
//
module trickle_interval_timer #(
  parameter int RAND_MAX_VALUE = tit_pkg::RAND_MAX_DEFAULT,
  parameter int EXP_MAX        = tit_pkg::EXP_MAX_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tit_pkg::tit_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tit_pkg::tit_out_t               out_data_o,
  input  logic                            cfg_we_i,
  input  logic [tit_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [tit_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  import tit_pkg::*;

  // Widths derived from the parameters
  localparam int RW     = $clog2(RAND_MAX_VALUE + 1);       // random word after clamp
  localparam int LEN_W  = TPS_W + EXP_MAX;                  // tps << exp
  localparam int HALF_W = CNT_W - 1;                        // floor(len/2)
  localparam int PROD_W = HALF_W + RW;                      // half * r
  localparam int DIV_W  = (LEN_W > PROD_W) ? LEN_W : PROD_W;
  localparam int DVR_W  = (RW > MS_W) ? RW : MS_W;

  // Sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;  // kick off length division
  localparam logic [2:0] ST_LEN   = 3'd2;  // len = (tps << exp) / 1000
  localparam logic [2:0] ST_MUL   = 3'd3;  // half * r
  localparam logic [2:0] ST_FRAC  = 3'd4;  // (half * r) / RAND_MAX
  localparam logic [2:0] ST_DONE  = 3'd5;  // hand result to output register

  logic [2:0] state_q, state_d;

  // Configuration registers
  logic [EXP_W-1:0]  min_exp_q;
  logic [DOUB_W-1:0] doub_q;
  logic [RED_W-1:0]  red_q;
  logic [TPS_W-1:0]  tps_q;

  // Timer state
  logic              running_q, running_d;
  logic [EXP_W-1:0]  cur_exp_q, cur_exp_d;
  logic              send_pending_q, send_pending_d;
  logic [CNT_W-1:0]  countdown_q, countdown_d;
  logic [CNT_W-1:0]  tail_q, tail_d;
  logic [RED_W-1:0]  heard_q, heard_d;
  logic              link_ok_q, link_ok_d;

  // Interval computation scratch
  logic [RW-1:0]     rnd_q, rnd_d;
  logic [CNT_W-1:0]  len_q, len_d;

  // Pending result and output register
  tit_out_t res_q, res_d;
  tit_out_t out_q;
  logic     out_valid_q;
  logic     out_load;

  // Serial units
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dividend, div_quot;
  logic [DVR_W-1:0]  div_divisor;
  logic              mul_start, mul_done;
  logic [PROD_W-1:0] mul_prod;

  // Misc combinational values
  logic              in_fire;
  logic [EXP_W-1:0]  min_eff, max_eff;
  logic [EXP_W:0]    max_sum;
  logic [CNT_W-1:0]  cd_dec;
  logic [CNT_W-1:0]  len_sat;
  logic [CNT_W-1:0]  fire_pt;
  logic              start_iv;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;

  // Effective exponent limits
  assign min_eff = (min_exp_q > EXP_W'(EXP_MAX)) ? EXP_W'(EXP_MAX) : min_exp_q;
  assign max_sum = {1'b0, min_eff} + {1'b0, doub_q};
  assign max_eff = (max_sum > (EXP_W+1)'(EXP_MAX)) ? EXP_W'(EXP_MAX) : max_sum[EXP_W-1:0];

  assign cd_dec = (countdown_q != '0) ? (countdown_q - CNT_W'(1)) : countdown_q;

  // Length saturates to 32 bits; firing point = half + frac
  assign len_sat = (|div_quot[DIV_W-1:CNT_W]) ? '1 : div_quot[CNT_W-1:0];
  assign fire_pt = {1'b0, len_q[CNT_W-1:1]} + {1'b0, div_quot[HALF_W-1:0]};

  // Divider is shared: length first, then the random fraction
  always_comb begin
    if (state_q == ST_SETUP) begin
      div_dividend = DIV_W'(tps_q) << cur_exp_q;
      div_divisor  = DVR_W'(MS_PER_SEC);
    end else begin
      div_dividend = DIV_W'(mul_prod);
      div_divisor  = DVR_W'(RAND_MAX_VALUE);
    end
  end

  assign div_start = (state_q == ST_SETUP) || ((state_q == ST_MUL) && mul_done);
  assign mul_start = (state_q == ST_LEN) && div_done;
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  tit_serial_div #(
    .W  (DIV_W),
    .DW (DVR_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  tit_serial_mul #(
    .A_W (HALF_W),
    .B_W (RW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (len_sat[CNT_W-1:1]),
    .b_i     (rnd_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Item decode and sequencing
  always_comb begin
    state_d        = state_q;
    running_d      = running_q;
    cur_exp_d      = cur_exp_q;
    send_pending_d = send_pending_q;
    countdown_d    = countdown_q;
    tail_d         = tail_q;
    heard_d        = heard_q;
    link_ok_d      = link_ok_q;
    rnd_d          = rnd_q;
    len_d          = len_q;
    res_d          = res_q;
    start_iv       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_d = '0;
          if (!running_q) begin
            // first item of any kind starts the timer
            running_d          = 1'b1;
            cur_exp_d          = min_eff;
            start_iv           = 1'b1;
            res_d.new_interval = 1'b1;
          end else begin
            case (in_data_i.func)
              FUNC_TICK: begin
                countdown_d = cd_dec;
                if (cd_dec == '0) begin
                  if (!link_ok_q && !in_data_i.link_ready) begin
                    countdown_d     = CNT_W'(tps_q);
                    res_d.postponed = 1'b1;
                  end else begin
                    link_ok_d = 1'b1;
                    if (send_pending_q) begin
                      if (red_q == '0 || heard_q < red_q) begin
                        res_d.send_now = 1'b1;
                      end else begin
                        res_d.suppressed = 1'b1;
                      end
                      send_pending_d = 1'b0;
                      countdown_d    = tail_q;
                    end else begin
                      // end of interval: grow and restart
                      if (cur_exp_q < max_eff) begin
                        cur_exp_d = cur_exp_q + EXP_W'(1);
                      end
                      start_iv           = 1'b1;
                      res_d.new_interval = 1'b1;
                    end
                  end
                end
              end
              FUNC_HEARD: begin
                if (heard_q != '1) begin
                  heard_d = heard_q + RED_W'(1);
                end
              end
              FUNC_RESET: begin
                if (cur_exp_q > min_eff) begin
                  cur_exp_d          = min_eff;
                  start_iv           = 1'b1;
                  res_d.new_interval = 1'b1;
                end
              end
              default: ;
            endcase
          end
          if (start_iv) begin
            send_pending_d = 1'b1;
            heard_d        = '0;
            rnd_d          = (in_data_i.random_value > RANDOM_W'(RAND_MAX_VALUE))
                             ? RW'(RAND_MAX_VALUE) : in_data_i.random_value[RW-1:0];
          end
          res_d.interval_exp = cur_exp_d;
          state_d            = start_iv ? ST_SETUP : ST_DONE;
        end
      end
      ST_SETUP: begin
        state_d = ST_LEN;
      end
      ST_LEN: begin
        if (div_done) begin
          len_d   = len_sat;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_d = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (div_done) begin
          countdown_d = fire_pt;
          tail_d      = len_q - fire_pt;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      running_q      <= 1'b0;
      cur_exp_q      <= '0;
      send_pending_q <= 1'b0;
      countdown_q    <= '0;
      tail_q         <= '0;
      heard_q        <= '0;
      link_ok_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      min_exp_q      <= MIN_EXP_RST;
      doub_q         <= DOUBLINGS_RST;
      red_q          <= RED_RST;
      tps_q          <= TPS_RST;
    end else begin
      state_q        <= state_d;
      running_q      <= running_d;
      cur_exp_q      <= cur_exp_d;
      send_pending_q <= send_pending_d;
      countdown_q    <= countdown_d;
      tail_q         <= tail_d;
      heard_q        <= heard_d;
      link_ok_q      <= link_ok_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_MIN_EXP:    min_exp_q <= cfg_wdata_i[EXP_W-1:0];
          REG_DOUBLINGS:  doub_q    <= cfg_wdata_i[DOUB_W-1:0];
          REG_REDUNDANCY: red_q     <= cfg_wdata_i[RED_W-1:0];
          REG_TPS:        tps_q     <= cfg_wdata_i[TPS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rnd_q <= rnd_d;
    len_q <= len_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // exponent stays within its bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_exp_q <= EXP_W'(EXP_MAX))
    else $error("interval exponent above EXP_MAX");

  // a result carries at most one of send, suppress, postpone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> $onehot0({res_q.send_now, res_q.suppressed, res_q.postponed}))
    else $error("conflicting result flags");

  // firing point never lies beyond the interval end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FRAC && div_done) |=> (countdown_q <= len_q))
    else $error("firing point beyond interval length");

  // a new interval clears the heard count and arms the send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETUP) |-> (send_pending_q && heard_q == '0 && res_q.new_interval))
    else $error("interval start without armed send");

  // once started, the timer keeps running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |=> running_q)
    else $error("timer stopped after start");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top - trickle interval timer testbench
// Drives timer events through the valid/ready input channel, rewrites the
// four timing registers between phases and checks every result transfer
// against a cycle-free timer model kept in a small scoreboard class.
// ============================================================================
module tb_top;
  import tit_pkg::*;

  // Spare selector value: ignored once the timer runs
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  // Cycles without any transfer before the run is declared hung. The worst
  // legal quiet spell is the long receiver hold-off plus one interval
  // computation plus a long sender gap.
  localparam int WATCHDOG_LIMIT = 10000;
  // Drain time after the last result; one interval computation and margin
  localparam int DRAIN_CYCLES   = 150;
  // Receiver hold-off used to back the block up into its input
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 300;

  // --------------------------------------------------------------------------
  // Scoreboard: timer model plus the queue of results still owed by the block
  // --------------------------------------------------------------------------
  class trickle_checker;
    // register copies
    logic [EXP_W-1:0]  min_exp;
    logic [DOUB_W-1:0] doublings;
    logic [RED_W-1:0]  redundancy;
    logic [TPS_W-1:0]  tps;
    // timer state
    bit                running;
    logic [EXP_W-1:0]  cur_exp;
    bit                send_pending;
    logic [CNT_W-1:0]  countdown;
    logic [CNT_W-1:0]  tail_delay;
    logic [7:0]        heard;
    bit                link_ok;

    tit_out_t          due_outcomes[$];
    int                mismatches;

    function new();
      min_exp      = MIN_EXP_RST;
      doublings    = DOUBLINGS_RST;
      redundancy   = RED_RST;
      tps          = TPS_RST;
      running      = 0;
      cur_exp      = '0;
      send_pending = 0;
      countdown    = '0;
      tail_delay   = '0;
      heard        = '0;
      link_ok      = 0;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MIN_EXP:    min_exp    = val[EXP_W-1:0];
        REG_DOUBLINGS:  doublings  = val[DOUB_W-1:0];
        REG_REDUNDANCY: redundancy = val[RED_W-1:0];
        REG_TPS:        tps        = val[TPS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [EXP_W-1:0] floor_exp();
      return (min_exp > EXP_MAX_DEFAULT) ? EXP_W'(EXP_MAX_DEFAULT) : min_exp;
    endfunction

    function logic [EXP_W-1:0] ceiling_exp();
      int lim;
      lim = int'(floor_exp()) + int'(doublings);
      return (lim > EXP_MAX_DEFAULT) ? EXP_W'(EXP_MAX_DEFAULT) : EXP_W'(lim);
    endfunction

    // Interval of 2^cur_exp ms in ticks; firing point in its second half
    function void open_interval(logic [RANDOM_W-1:0] rnd);
      longint unsigned span, half, r, fire;
      span = ((64'd1 << cur_exp) * 64'(tps)) / 64'(MS_PER_SEC);
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      r = (64'(rnd) > 64'(RAND_MAX_DEFAULT)) ? 64'(RAND_MAX_DEFAULT) : 64'(rnd);
      half = span / 2;
      fire = half + (half * r) / 64'(RAND_MAX_DEFAULT);
      tail_delay   = CNT_W'(span - fire);
      countdown    = CNT_W'(fire);
      send_pending = 1;
      heard        = '0;
    endfunction

    // Accepted input transfer: advance the model, queue the owed result
    function void accept_event(tit_in_t ev);
      tit_out_t res;
      bit       fire_ok;
      res = '0;
      if (!running) begin
        // any event starts an idle timer and does nothing else
        running = 1;
        cur_exp = floor_exp();
        open_interval(ev.random_value);
        res.new_interval = 1'b1;
      end else begin
        case (ev.func)
          FUNC_TICK: begin
            if (countdown != 0) countdown--;
            if (countdown == 0) begin
              fire_ok = 1;
              if (!link_ok) begin
                if (ev.link_ready) begin
                  link_ok = 1;
                end else begin
                  // no link yet: retry one second later
                  countdown     = CNT_W'(tps);
                  res.postponed = 1'b1;
                  fire_ok       = 0;
                end
              end
              if (fire_ok) begin
                if (send_pending) begin
                  if (redundancy == 0 || heard < redundancy) res.send_now = 1'b1;
                  else res.suppressed = 1'b1;
                  send_pending = 0;
                  countdown    = tail_delay;
                end else begin
                  if (cur_exp < ceiling_exp()) cur_exp++;
                  open_interval(ev.random_value);
                  res.new_interval = 1'b1;
                end
              end
            end
          end
          FUNC_HEARD: begin
            if (heard != 8'hFF) heard++;
          end
          FUNC_RESET: begin
            if (cur_exp > floor_exp()) begin
              cur_exp = floor_exp();
              open_interval(ev.random_value);
              res.new_interval = 1'b1;
            end
          end
          default: ;
        endcase
      end
      res.interval_exp = cur_exp;
      due_outcomes.push_back(res);
    endfunction

    function void cmp_field(string fname, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d, actual %0d", $time, fname, want, got);
        mismatches++;
      end
    endfunction

    // Result transfer: compare against the oldest owed result
    function void check_outcome(tit_out_t got);
      tit_out_t want;
      if (due_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = due_outcomes.pop_front();
      cmp_field("send_now",     want.send_now,     got.send_now);
      cmp_field("suppressed",   want.suppressed,   got.suppressed);
      cmp_field("postponed",    want.postponed,    got.postponed);
      cmp_field("new_interval", want.new_interval, got.new_interval);
      cmp_field("interval_exp", want.interval_exp, got.interval_exp);
    endfunction

    function int pending();
      return due_outcomes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  tit_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  tit_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  trickle_interval_timer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata)
  );

  trickle_checker sb = new();
  int             accepted_events;
  int             quiet_cycles;
  int             sender_burst;

  // All inputs known from time zero
  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: both channels are sampled at the edge, before the edge's updates
  // land, so the model sees exactly the transfers the block sees. The result
  // side is handled first; an item never completes on its own accept edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_outcome(out_data);
      if (in_valid && in_ready) begin
        sb.accept_event(in_data);
        accepted_events++;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a hung handshake anywhere ends the run as a failure
  initial begin
    quiet_cycles = 0;
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Mostly back-to-back, some short gaps, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure with calm stretches, plus one long
  // hold-off once enough traffic has gone by so that the block backs up and
  // drops in_ready while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin
    int  stall_left;
    int  calm_left;
    bit  long_hold_done;
    int  r;
    stall_left     = 0;
    calm_left      = 0;
    long_hold_done = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!long_hold_done && accepted_events >= HOLD_AFTER) begin
        long_hold_done = 1;
        stall_left     = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        out_ready <= 1'b1;
        calm_left--;
      end else begin
        out_ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 70) ;
        else if (r < 85) stall_left = $urandom_range(1, 3);
        else if (r < 93) calm_left = $urandom_range(20, 80);
        else if (r < 99) stall_left = $urandom_range(4, 15);
        else stall_left = $urandom_range(40, 120);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // One event: optional gap, then hold valid until the transfer edge. Valid
  // stays up on exit so a back-to-back event takes a single assignment.
  task automatic offer(input logic [FUNC_W-1:0] func, input logic [RANDOM_W-1:0] rnd,
                       input logic ready);
    tit_in_t ev;
    int      gap;
    ev.func         = func;
    ev.random_value = rnd;
    ev.link_ready   = ready;
    if (sender_burst > 0) begin
      gap = 0;
      sender_burst--;
    end else begin
      if ($urandom_range(0, 49) == 0) sender_burst = $urandom_range(20, 60);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic offer_rand(input logic [FUNC_W-1:0] func);
    offer(func, RANDOM_W'($urandom()), 1'($urandom_range(0, 1)));
  endtask

  // Stop sending and wait until every owed result has come back. The extra
  // edge lets the monitor book the last accepted event first.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges; block is idle here
  task automatic configure(input logic [CFG_DATA_W-1:0] v_min,
                           input logic [CFG_DATA_W-1:0] v_doub,
                           input logic [CFG_DATA_W-1:0] v_red,
                           input logic [CFG_DATA_W-1:0] v_tps);
    logic [CFG_DATA_W-1:0] vals[4];
    vals[REG_MIN_EXP]    = v_min;
    vals[REG_DOUBLINGS]  = v_doub;
    vals[REG_REDUNDANCY] = v_red;
    vals[REG_TPS]        = v_tps;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_ADDR_W'(i);
      cfg_wdata <= vals[i];
      sb.set_reg(CFG_ADDR_W'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random traffic shaped as timer usage: tick runs long enough to reach
  // firing points and interval ends, heard bursts to hit the redundancy
  // threshold (now and then past saturation), reset requests, and the odd
  // spare selector as noise (not counted, the block ignores it).
  task automatic run_mix(input int budget);
    int done;
    int sel;
    int n;
    done = 0;
    while (done < budget) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        n = $urandom_range(1, 40);
        repeat (n) offer_rand(FUNC_TICK);
        done += n;
      end else if (sel < 71) begin
        n = $urandom_range(1, 6);
        repeat (n) offer_rand(FUNC_HEARD);
        done += n;
      end else if (sel < 72) begin
        n = $urandom_range(256, 300);
        repeat (n) offer_rand(FUNC_HEARD);
        done += n;
      end else if (sel < 82) begin
        offer_rand(FUNC_RESET);
        done++;
      end else if (sel < 87) begin
        offer_rand(FUNC_SPARE);
      end else begin
        n = $urandom_range(40, 120);
        repeat (n) offer_rand(FUNC_TICK);
        done += n;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    accepted_events = 0;
    sender_burst    = 0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two-tick intervals at exponent 10, redundancy 1, room for
    // one doubling. Link stays down first so firings get postponed.
    configure(11'd10, 11'd1, 11'd1, 11'd2);
    offer(FUNC_SPARE, 16'hFFFF, 1'b0);  // start while idle via spare selector
    offer(FUNC_TICK,  16'h0000, 1'b0);
    offer(FUNC_HEARD, 16'h0000, 1'b0);
    offer(FUNC_TICK,  16'hFFFF, 1'b0);  // fires without link: postponed
    offer(FUNC_TICK,  16'h0000, 1'b0);
    offer(FUNC_TICK,  16'h0000, 1'b0);  // postponed again
    offer(FUNC_HEARD, 16'hFFFF, 1'b1);
    offer(FUNC_TICK,  16'hFFFF, 1'b1);
    offer(FUNC_TICK,  16'hFFFF, 1'b1);  // link comes up, redundancy hit
    offer(FUNC_TICK,  16'h0000, 1'b1);  // zero tail: interval doubles
    offer(FUNC_RESET, 16'hFFFF, 1'b0);  // back to the minimum
    offer(FUNC_RESET, 16'h0000, 1'b0);  // already at minimum: no effect
    offer(FUNC_SPARE, 16'h5A5A, 1'b1);  // ignored while running
    repeat (8) offer(FUNC_TICK, 16'hA5A5, 1'b0);  // sends, doubling capped
    settle();

    // Random register mix with short intervals
    configure(11'($urandom_range(0, 3)), 11'($urandom_range(0, 6)),
              11'($urandom_range(0, 8)), 11'($urandom_range(900, 2047)));
    run_mix(180);
    settle();

    // Redundancy off: never suppress
    configure(11'd0, 11'd3, 11'd0, 11'd1000);
    run_mix(180);
    settle();

    // Zero-length intervals climb to the exponent cap; redundancy written
    // with all data bits set lands as the 8-bit maximum
    configure(11'd22, 11'd5, 11'h7FF, 11'd0);
    run_mix(110);
    settle();

    // All-ones minimum, doublings and tps: minimum above the cap, longest intervals
    configure(11'h7FF, 11'd31, 11'd0, 11'h7FF);
    run_mix(25);
    settle();

    // No doublings allowed; reset requests pull the exponent down
    configure(11'd1, 11'd0, 11'd2, 11'd2047);
    run_mix(150);
    settle();

    // Full doubling range, threshold at saturation, saturating heard burst
    configure(11'd0, 11'd24, 11'd255, 11'd1024);
    repeat (300) offer_rand(FUNC_HEARD);
    run_mix(195);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
